>>> sv/mdcs_pkg.sv
// Shared types and constants for the minimum-distance corner selector.
// No dependencies; every other file in the block imports this package.
`default_nettype none

package mdcs_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int COORD_BITS  = 12;
    localparam int PORT_BITS   = 12;
    localparam int MIND_BITS   = 12;
    localparam int MAXC_BITS   = 16;
    localparam int PIDX_BITS   = 20;
    localparam int CFG_DBITS   = 16;

    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int SUM_BITS  = SQ_BITS + 1;
    localparam int LIM_BITS  = 2 * MIND_BITS;
    localparam int CMP_BITS  = (SUM_BITS > LIM_BITS) ? SUM_BITS : LIM_BITS;

    // Configuration register indexes.
    localparam logic CFG_MIN_DISTANCE = 1'b0;
    localparam logic CFG_MAX_CORNERS  = 1'b1;

    // A candidate corner as it travels down the chain of kept points.
    typedef struct packed {
        logic                  valid;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  has_proj;
        logic [PIDX_BITS-1:0]  pidx;
        logic                  close;
        logic                  captured;
    } t_cand;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

>>> sv/min_distance_corner_selector.sv
// Items stream through the chain of kept-point cells and then the result register;
// throughput is one item per cycle while the output is not stalled. Each cell squares
// the offsets into registers, then adds and compares, and registers the item again.
// A stalled output freezes the whole chain and the input stalls with it.
// Reset empties every cell and clears the selection counter, the finish flag and both registers.
// Depends on mdcs_pkg, mdcs_cell and mdcs_select.
`default_nettype none

module min_distance_corner_selector
    import mdcs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [PORT_BITS-1:0] i_corner_x,
    input  wire logic [PORT_BITS-1:0] i_corner_y,
    input  wire logic                 i_has_projection,
    input  wire logic [PIDX_BITS-1:0] i_projection_index,

    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_is_good,
    output logic                      o_is_selected,
    output logic [PIDX_BITS-1:0]      o_selected_index,
    output logic                      o_finished,
    output logic                      o_store_overflow,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [CFG_DBITS-1:0] i_cfg_data
);

    logic                 r_supp;
    logic [LIM_BITS-1:0]  r_limit;
    logic [MAXC_BITS-1:0] r_max_corners;

    logic                 w_en;
    logic [MIND_BITS-1:0] w_mind;
    t_cand                w_link [STORE_DEPTH+1];

    assign w_en        = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;
    assign w_mind      = i_cfg_data[MIND_BITS-1:0];

    // The squared limit is formed once, when the register is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supp        <= 1'b0;
            r_limit       <= '0;
            r_max_corners <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_DISTANCE: begin
                    r_supp  <= (w_mind != '0);
                    r_limit <= LIM_BITS'(w_mind) * LIM_BITS'(w_mind);
                end
                CFG_MAX_CORNERS: begin
                    r_max_corners <= i_cfg_data[MAXC_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_link[0]          = '0;
        w_link[0].valid    = i_in_valid && w_en;
        w_link[0].x        = i_corner_x[COORD_BITS-1:0];
        w_link[0].y        = i_corner_y[COORD_BITS-1:0];
        w_link[0].has_proj = i_has_projection;
        w_link[0].pidx     = i_projection_index;
    end

    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        mdcs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_supp  (r_supp),
            .i_limit (r_limit),
            .i_cand  (w_link[g]),
            .o_cand  (w_link[g+1])
        );
    end

    mdcs_select u_select (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_supp           (r_supp),
        .i_max_corners    (r_max_corners),
        .i_cand           (w_link[STORE_DEPTH]),
        .o_valid          (o_out_valid),
        .o_is_good        (o_is_good),
        .o_is_selected    (o_is_selected),
        .o_selected_index (o_selected_index),
        .o_finished       (o_finished),
        .o_store_overflow (o_store_overflow)
    );

endmodule

`default_nettype wire

>>> sv/mdcs_cell.sv
// One cell of the kept-corner chain: holds one kept point and tests each passing item.
// Depends on mdcs_pkg.
`default_nettype none

module mdcs_cell
    import mdcs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_supp,
    input  wire logic [LIM_BITS-1:0] i_limit,
    input  wire t_cand               i_cand,
    output t_cand                    o_cand
);

    logic                  r_full;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;

    t_cand                 r_a_cand;
    logic                  r_a_chk;
    logic [SQ_BITS-1:0]    r_dx2;
    logic [SQ_BITS-1:0]    r_dy2;

    t_cand                 r_b_cand;

    t_cand                 n_a_cand;
    t_cand                 n_b_cand;

    logic                  w_cap;
    logic [COORD_BITS-1:0] w_dx;
    logic [COORD_BITS-1:0] w_dy;
    logic [CMP_BITS-1:0]   w_sum;
    logic                  w_near;

    // An empty cell takes the first item that is still good; cells fill in order,
    // so every earlier cell has already been checked by then.
    assign w_cap = i_cand.valid && !r_full && i_supp && !i_cand.close && !i_cand.captured;
    assign w_dx  = abs_diff(i_cand.x, r_px);
    assign w_dy  = abs_diff(i_cand.y, r_py);
    assign w_sum = CMP_BITS'(r_dx2) + CMP_BITS'(r_dy2);
    assign w_near = r_a_chk && (w_sum < CMP_BITS'(i_limit));

    always_comb begin
        n_a_cand          = i_cand;
        n_a_cand.captured = i_cand.captured | w_cap;
        n_b_cand          = r_a_cand;
        n_b_cand.close    = r_a_cand.close | w_near;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full         <= 1'b0;
            r_a_cand.valid <= 1'b0;
            r_b_cand.valid <= 1'b0;
        end else if (i_en) begin
            if (w_cap) begin
                r_full <= 1'b1;
                r_px   <= i_cand.x;
                r_py   <= i_cand.y;
            end
            r_a_cand <= n_a_cand;
            r_a_chk  <= i_cand.valid && r_full;
            r_dx2    <= SQ_BITS'(w_dx) * SQ_BITS'(w_dx);
            r_dy2    <= SQ_BITS'(w_dy) * SQ_BITS'(w_dy);

            r_b_cand <= n_b_cand;
        end
    end

    assign o_cand = r_b_cand;

endmodule

`default_nettype wire

>>> sv/mdcs_select.sv
// End of the chain: selection counting, the finish flag and the result register.
// Depends on mdcs_pkg.
`default_nettype none

module mdcs_select
    import mdcs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_supp,
    input  wire logic [MAXC_BITS-1:0] i_max_corners,
    input  wire t_cand                i_cand,
    output logic                      o_valid,
    output logic                      o_is_good,
    output logic                      o_is_selected,
    output logic [PIDX_BITS-1:0]      o_selected_index,
    output logic                      o_finished,
    output logic                      o_store_overflow
);

    logic                 r_valid;
    logic [MAXC_BITS-1:0] r_count;
    logic                 r_done;
    logic                 r_good;
    logic                 r_sel;
    logic [PIDX_BITS-1:0] r_index;
    logic                 r_fin;
    logic                 r_ovf;

    logic                 w_good;
    logic                 w_sel;
    logic [MAXC_BITS-1:0] n_count;

    assign w_good  = !i_cand.close;
    assign w_sel   = w_good && i_cand.has_proj;
    assign n_count = r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_cand.valid;
            if (i_cand.valid) begin
                if (r_done) begin
                    r_good  <= 1'b0;
                    r_sel   <= 1'b0;
                    r_index <= '0;
                    r_fin   <= 1'b1;
                    r_ovf   <= 1'b0;
                end else begin
                    r_good  <= w_good;
                    r_sel   <= w_sel;
                    r_index <= w_sel ? i_cand.pidx : '0;
                    r_fin   <= 1'b0;
                    // A good corner that found no free cell overflowed the store.
                    r_ovf   <= w_good && i_supp && !i_cand.captured;
                    if (w_sel) begin
                        r_count <= n_count;
                        if (i_max_corners != '0 && n_count >= i_max_corners) begin
                            r_done <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_is_good        = r_good;
    assign o_is_selected    = r_sel;
    assign o_selected_index = r_index;
    assign o_finished       = r_fin;
    assign o_store_overflow = r_ovf;

endmodule

`default_nettype wire

>>> bench/corner_check_pkg.sv
// Scoreboard for the minimum-distance corner selector bench: item types, a model of the
// kept-corner store and counters, and the queue of awaited results.
// Depends on mdcs_pkg for widths, store depth and register indexes.
package corner_check_pkg;

    import mdcs_pkg::*;

    typedef struct packed {
        logic [PORT_BITS-1:0] x;
        logic [PORT_BITS-1:0] y;
        logic                 has_proj;
        logic [PIDX_BITS-1:0] pidx;
    } t_corner;

    typedef struct packed {
        logic                 good;
        logic                 selected;
        logic [PIDX_BITS-1:0] index;
        logic                 finished;
        logic                 overflow;
    } t_verdict;

    class corner_scoreboard;
        logic [COORD_BITS-1:0] kept_x [STORE_DEPTH];
        logic [COORD_BITS-1:0] kept_y [STORE_DEPTH];
        int unsigned           kept_count = 0;
        logic [MAXC_BITS-1:0]  sel_count = '0;
        logic [MAXC_BITS-1:0]  max_corners = '0;
        logic [MIND_BITS-1:0]  min_dist = '0;
        bit                    done = 1'b0;
        t_verdict              awaited[$];
        int unsigned           failures = 0;
        int unsigned           results_seen = 0;

        function void set_reg(logic idx, logic [CFG_DBITS-1:0] data);
            if (idx == CFG_MIN_DISTANCE) begin
                min_dist = data[MIND_BITS-1:0];
            end else begin
                max_corners = data[MAXC_BITS-1:0];
            end
        endfunction

        function bit clear_of_kept(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
            longint unsigned reach, dx, dy;
            int unsigned i;
            reach = longint'(min_dist) * longint'(min_dist);
            for (i = 0; i < kept_count; i++) begin
                dx = (x >= kept_x[i]) ? longint'(x - kept_x[i]) : longint'(kept_x[i] - x);
                dy = (y >= kept_y[i]) ? longint'(y - kept_y[i]) : longint'(kept_y[i] - y);
                if (dx * dx + dy * dy < reach) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        // Works out the result of one accepted item and queues it.
        function void note_corner(t_corner c);
            t_verdict v;
            logic [COORD_BITS-1:0] x, y;
            v = '0;
            x = c.x[COORD_BITS-1:0];
            y = c.y[COORD_BITS-1:0];
            if (done) begin
                v.finished = 1'b1;
                awaited.insert(awaited.size(), v);
                return;
            end
            v.good = 1'b1;
            if (min_dist != 0) begin
                v.good = clear_of_kept(x, y);
                if (v.good) begin
                    if (kept_count < STORE_DEPTH) begin
                        kept_x[kept_count] = x;
                        kept_y[kept_count] = y;
                        kept_count++;
                    end else begin
                        v.overflow = 1'b1;
                    end
                end
            end
            if (v.good && c.has_proj) begin
                v.selected = 1'b1;
                v.index    = c.pidx;
                sel_count  = sel_count + 1'b1;
                if (max_corners != 0 && sel_count >= max_corners) begin
                    done = 1'b1;
                end
            end
            awaited.insert(awaited.size(), v);
        endfunction

        task report(string msg);
            failures++;
            // Printing is capped so a badly broken block cannot flood the log.
            if (failures <= 100) begin
                $display("mismatch on result %0d: %s", results_seen, msg);
            end
        endtask

        task check_result(t_verdict got);
            t_verdict want;
            results_seen++;
            if (awaited.size() == 0) begin
                report("result arrived with none expected");
                return;
            end
            want = awaited.pop_front();
            if (got.good !== want.good)
                report($sformatf("is_good %b, expected %b", got.good, want.good));
            if (got.selected !== want.selected)
                report($sformatf("is_selected %b, expected %b", got.selected, want.selected));
            if (got.index !== want.index)
                report($sformatf("selected_index %h, expected %h", got.index, want.index));
            if (got.finished !== want.finished)
                report($sformatf("finished %b, expected %b", got.finished, want.finished));
            if (got.overflow !== want.overflow)
                report($sformatf("store_overflow %b, expected %b", got.overflow, want.overflow));
        endtask
    endclass

endpackage

>>> bench/tb_min_distance_corner_selector.sv
// Self-checking bench for min_distance_corner_selector: directed and random corner streams
// under several spacing and limit settings, with random gaps and stalls on both sides.
// Depends on mdcs_pkg and corner_check_pkg.
module tb_min_distance_corner_selector;

    import mdcs_pkg::*;
    import corner_check_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_MAX   = (1 << PORT_BITS) - 1;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [PORT_BITS-1:0] i_corner_x = '0;
    logic [PORT_BITS-1:0] i_corner_y = '0;
    logic                 i_has_projection = 1'b0;
    logic [PIDX_BITS-1:0] i_projection_index = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_is_good;
    logic                 o_is_selected;
    logic [PIDX_BITS-1:0] o_selected_index;
    logic                 o_finished;
    logic                 o_store_overflow;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = CFG_MIN_DISTANCE;
    logic [CFG_DBITS-1:0] i_cfg_data = '0;

    corner_scoreboard sb;
    bit               quiet = 1'b0;
    int               hold = 0;
    int unsigned      cycle_count = 0;

    min_distance_corner_selector DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_corner_x         (i_corner_x),
        .i_corner_y         (i_corner_y),
        .i_has_projection   (i_has_projection),
        .i_projection_index (i_projection_index),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_is_good          (o_is_good),
        .o_is_selected      (o_is_selected),
        .o_selected_index   (o_selected_index),
        .o_finished         (o_finished),
        .o_store_overflow   (o_store_overflow),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: check at the rising edge, then stall for a freshly drawn number of cycles.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_result({o_is_good, o_is_selected, o_selected_index,
                                 o_finished, o_store_overflow});
                hold = quiet ? 0 : $urandom_range(16);
            end
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_corner corner_at(int x, int y, bit hp, int pidx);
        t_corner c;
        c.x        = PORT_BITS'(x);
        c.y        = PORT_BITS'(y);
        c.has_proj = hp;
        c.pidx     = PIDX_BITS'(pidx);
        return c;
    endfunction

    // Uniform corner, or one placed around a kept corner so the spacing test sits
    // right at its boundary.
    function automatic t_corner make_corner(int near_pct);
        t_corner c;
        int k, r, cx, cy;
        c = corner_at($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                      1'($urandom_range(1)), $urandom_range((1 << PIDX_BITS) - 1));
        if (sb.kept_count != 0 && $urandom_range(99) < near_pct) begin
            k  = $urandom_range(sb.kept_count - 1);
            r  = int'(sb.min_dist) + 2;
            cx = int'(sb.kept_x[k]) + int'($urandom_range(2 * r)) - r;
            cy = int'(sb.kept_y[k]) + int'($urandom_range(2 * r)) - r;
            c.x = PORT_BITS'((cx < 0) ? 0 : (cx > COORD_MAX) ? COORD_MAX : cx);
            c.y = PORT_BITS'((cy < 0) ? 0 : (cy > COORD_MAX) ? COORD_MAX : cy);
        end
        return c;
    endfunction

    // Spacing register word with random junk above the 12 bits that count.
    function automatic logic [CFG_DBITS-1:0] spacing_word(int md);
        return CFG_DBITS'(($urandom_range(15) << MIND_BITS) | md);
    endfunction

    // Called and returns at a falling edge.
    task automatic send_corner(t_corner c);
        int gap;
        gap = quiet ? 0 : $urandom_range(16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_corner_x         <= c.x;
        i_corner_y         <= c.y;
        i_has_projection   <= c.has_proj;
        i_projection_index <= c.pidx;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_corner(c);
        @(negedge i_clk);
    endtask

    task automatic run_random(int count, int near_pct);
        repeat (count) begin
            if ($urandom_range(39) == 0) quiet = !quiet;
            send_corner(make_corner(near_pct));
        end
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DBITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int md;
        sb = new;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Suppression off, no limit: every corner is good, repeats included.
        write_reg(CFG_MIN_DISTANCE, '0);
        write_reg(CFG_MAX_CORNERS, '0);
        send_corner(corner_at(0, 0, 1'b0, 0));
        send_corner(corner_at(COORD_MAX, COORD_MAX, 1'b1, 20'hFFFFF));
        send_corner(corner_at(0, COORD_MAX, 1'b1, 0));
        send_corner(corner_at(COORD_MAX, 0, 1'b1, 20'hAAAAA));
        send_corner(corner_at(0, 0, 1'b1, 20'h55555));
        send_corner(corner_at(0, 0, 1'b0, 20'hFFFFF));
        run_random(150, 0);
        drain();

        // Widest spacing: only the four image corners fit, one step short is rejected.
        write_reg(CFG_MIN_DISTANCE, spacing_word(4095));
        write_reg(CFG_MAX_CORNERS, 16'hFFFF);
        send_corner(corner_at(0, 0, 1'b1, $urandom_range(20'hFFFFF)));
        send_corner(corner_at(COORD_MAX - 1, 0, 1'b1, $urandom_range(20'hFFFFF)));
        send_corner(corner_at(COORD_MAX, 0, 1'b0, $urandom_range(20'hFFFFF)));
        send_corner(corner_at(0, COORD_MAX, 1'b1, $urandom_range(20'hFFFFF)));
        send_corner(corner_at(COORD_MAX, COORD_MAX, 1'b1, $urandom_range(20'hFFFFF)));
        send_corner(corner_at(2048, 2048, 1'b1, $urandom_range(20'hFFFFF)));
        send_corner(corner_at(0, 0, 1'b1, $urandom_range(20'hFFFFF)));
        drain();

        // Medium spacing: exact spacing passes, one less fails.
        md = $urandom_range(150, 600);
        write_reg(CFG_MIN_DISTANCE, spacing_word(md));
        send_corner(corner_at(md, 0, 1'b1, $urandom_range(20'hFFFFF)));
        send_corner(corner_at(0, md - 1, 1'b1, $urandom_range(20'hFFFFF)));
        send_corner(corner_at(0, md, 1'b1, $urandom_range(20'hFFFFF)));
        run_random(250, 50);
        drain();

        // Tight spacing fills the store and then overflows it.
        write_reg(CFG_MIN_DISTANCE, spacing_word($urandom_range(1, 4)));
        run_random(350, 30);
        drain();

        // Suppression off with a full store: no overflow reported.
        write_reg(CFG_MIN_DISTANCE, spacing_word(0));
        run_random(100, 30);
        drain();

        write_reg(CFG_MIN_DISTANCE, spacing_word($urandom_range(5, 60)));
        write_reg(CFG_MAX_CORNERS, CFG_DBITS'($urandom_range(16'hFFFF)));
        run_random(150, 40);
        drain();

        // Selection limit: either lowered below the count or reached exactly.
        // Once finished, the block reports every following corner as finished and selects none.
        if ($urandom_range(1)) begin
            write_reg(CFG_MAX_CORNERS, 16'd1);
        end else begin
            write_reg(CFG_MAX_CORNERS,
                      CFG_DBITS'(int'(sb.sel_count) + int'($urandom_range(3, 12))));
        end
        run_random(80, 30);
        drain();

        repeat (2 * STORE_DEPTH + 16) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
